// ----- rtl/core/cfe_pkg.sv -----
// Shared types, codes and helper functions for the calendar field editor.
// No dependencies; every other file of the block imports this package.
package cfe_pkg;

	localparam int ADDR_W      = 3;
	localparam int REG_SEL_BIT = 2;
	localparam int CENT_LSB    = 19;

	// Commands
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_NEXT = 2'd1;
	localparam logic [1:0] CMD_INC  = 2'd2;
	localparam logic [1:0] CMD_DEC  = 2'd3;

	// Field selector codes
	localparam logic [2:0] FIELD_MONTH  = 3'd0;
	localparam logic [2:0] FIELD_DAY    = 3'd1;
	localparam logic [2:0] FIELD_YEAR   = 3'd2;
	localparam logic [2:0] FIELD_HOUR   = 3'd3;
	localparam logic [2:0] FIELD_MINUTE = 3'd4;
	localparam logic [2:0] FIELD_SECOND = 3'd5;

	// Register indexes
	localparam logic REG_YEAR_LO = 1'b0;
	localparam logic REG_YEAR_HI = 1'b1;

	localparam logic [13:0] YEAR_LO_RST = 14'd2000;
	localparam logic [13:0] YEAR_HI_RST = 14'd2099;

	localparam logic [3:0] MONTH_LAST   = 4'd12;
	localparam logic [4:0] HOUR_LAST    = 5'd23;
	localparam logic [5:0] HOUR_MOD     = 6'd24;
	localparam logic [5:0] MINSEC_LAST  = 6'd59;
	localparam logic [6:0] MINSEC_MOD   = 7'd60;

	// y is a multiple of 25 iff (y * 25^-1 mod 2^14) <= floor((2^14-1)/25)
	localparam logic [13:0] DIV25_INV = 14'd7209;
	localparam logic [13:0] DIV25_LIM = 14'd655;
	// floor(y/100) = (y * 5243) >> 19 for any 14-bit y
	localparam logic [12:0] DIV100_MUL = 13'd5243;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
		logic [13:0] load_year;
		logic [4:0]  load_hours;
		logic [5:0]  load_minutes;
		logic [5:0]  load_seconds;
	} cfe_in_t;

	typedef struct packed {
		logic [2:0]  field_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [13:0] year_out;
		logic [4:0]  hours_out;
		logic [5:0]  minutes_out;
		logic [5:0]  seconds_out;
		logic [2:0]  weekday_out;
		logic        edited_out;
	} cfe_out_t;

	typedef struct packed {
		logic [2:0]  field;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic        edited;
	} edit_state_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} wd_ctrl_t;

	localparam edit_state_t STATE_RST = '{
		field:   FIELD_MONTH,
		month:   4'd1,
		day:     5'd1,
		year:    YEAR_LO_RST,
		hours:   5'd0,
		minutes: 6'd0,
		seconds: 6'd0,
		edited:  1'b0
	};

	// Gregorian leap year: y%4==0 and (y%100!=0 or y%400==0), with
	// y%100==0 <=> y%25==0 once y%4==0, and y%400==0 <=> y%16==0 and y%25==0.
	function automatic logic is_leap(input logic [13:0] y);
		logic [13:0] p;
		p = y * DIV25_INV;
		return (y[1:0] == 2'b00) && ((p > DIV25_LIM) || (y[3:0] == 4'b0000));
	endfunction

	// Months outside 1..12 count as 31 days.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [3:0] idx;
		idx = m - 4'd1;
		if (m == 4'd0 || m > MONTH_LAST)
			return 5'd31;
		else if (m == 4'd2 && leap)
			return 5'd29;
		else
			return MONTH_LEN[idx];
	endfunction

	// floor(13*(m+1)/5) for the shifted month 3..15
	function automatic logic [5:0] wd_month_term(input logic [4:0] m);
		logic [5:0] t;
		unique case (m)
			5'd3:    t = 6'd10;
			5'd4:    t = 6'd13;
			5'd5:    t = 6'd15;
			5'd6:    t = 6'd18;
			5'd7:    t = 6'd20;
			5'd8:    t = 6'd23;
			5'd9:    t = 6'd26;
			5'd10:   t = 6'd28;
			5'd11:   t = 6'd31;
			5'd12:   t = 6'd33;
			5'd13:   t = 6'd36;
			5'd14:   t = 6'd39;
			5'd15:   t = 6'd41;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

	// Zeller h (0 = Saturday) to 1 Monday .. 7 Sunday
	function automatic logic [2:0] wd_code(input logic [2:0] h);
		logic [2:0] w;
		unique case (h)
			3'd0:    w = 3'd6;
			3'd1:    w = 3'd7;
			3'd2:    w = 3'd1;
			3'd3:    w = 3'd2;
			3'd4:    w = 3'd3;
			3'd5:    w = 3'd4;
			3'd6:    w = 3'd5;
			default: w = 3'd1;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/cfe_edit_step.sv -----
// Next-state logic of the edit registers: load, field select, wrap and day clamp.
// Depends on cfe_pkg.
module cfe_edit_step (
	input  cfe_pkg::edit_state_t cur,
	input  cfe_pkg::cfe_in_t     cmd,
	input  logic [13:0]          year_lo,
	input  logic [13:0]          year_hi,
	output cfe_pkg::edit_state_t nxt
);
	import cfe_pkg::*;

	logic        bump;
	logic        up;
	logic [3:0]  mo_n;
	logic [13:0] yr_n;
	logic [4:0]  lim;
	logic [4:0]  day_fit;
	logic [5:0]  d_inc;
	logic [5:0]  h_inc;
	logic [6:0]  mi_inc;
	logic [6:0]  se_inc;

	assign bump = (cmd.command == CMD_INC) || (cmd.command == CMD_DEC);
	assign up   = (cmd.command == CMD_INC);

	// month and year candidates first, so one leap test and one length lookup serve all
	always_comb begin
		mo_n = cur.month;
		yr_n = cur.year;
		if (bump && cur.field == FIELD_MONTH) begin
			if (up)
				mo_n = (cur.month >= MONTH_LAST) ? 4'd1 : cur.month + 4'd1;
			else
				mo_n = (cur.month <= 4'd1) ? MONTH_LAST : cur.month - 4'd1;
		end
		if (bump && cur.field == FIELD_YEAR) begin
			if (up)
				yr_n = (cur.year >= year_hi) ? year_lo : cur.year + 14'd1;
			else
				yr_n = (cur.year <= year_lo) ? year_hi : cur.year - 14'd1;
		end
	end

	assign lim     = month_days(mo_n, is_leap(yr_n));
	assign day_fit = (cur.day == 5'd0) ? 5'd1 : ((cur.day > lim) ? lim : cur.day);
	assign d_inc   = {1'b0, cur.day} + 6'd1;
	assign h_inc   = {1'b0, cur.hours} + 6'd1;
	assign mi_inc  = {1'b0, cur.minutes} + 7'd1;
	assign se_inc  = {1'b0, cur.seconds} + 7'd1;

	always_comb begin
		nxt = cur;
		unique case (cmd.command)
			CMD_LOAD: begin
				nxt.field   = FIELD_MONTH;
				nxt.month   = cmd.load_month;
				nxt.day     = cmd.load_day;
				nxt.year    = cmd.load_year;
				nxt.hours   = cmd.load_hours;
				nxt.minutes = cmd.load_minutes;
				nxt.seconds = cmd.load_seconds;
			end
			CMD_NEXT: begin
				nxt.field = (cur.field >= FIELD_SECOND) ? FIELD_MONTH : cur.field + 3'd1;
			end
			CMD_INC, CMD_DEC: begin
				nxt.edited = 1'b1;
				unique case (cur.field)
					FIELD_MONTH, FIELD_YEAR: begin
						nxt.month = mo_n;
						nxt.year  = yr_n;
						nxt.day   = day_fit;
					end
					FIELD_DAY: begin
						if (up)
							nxt.day = (d_inc > {1'b0, lim}) ? 5'd1 : d_inc[4:0];
						else
							nxt.day = (cur.day <= 5'd1) ? lim : cur.day - 5'd1;
					end
					FIELD_HOUR: begin
						if (up)
							nxt.hours = (h_inc >= HOUR_MOD) ? 5'(h_inc - HOUR_MOD) : h_inc[4:0];
						else
							nxt.hours = (cur.hours == 5'd0) ? HOUR_LAST : cur.hours - 5'd1;
					end
					FIELD_MINUTE: begin
						if (up)
							nxt.minutes = (mi_inc >= MINSEC_MOD) ? 6'(mi_inc - MINSEC_MOD)
								: mi_inc[5:0];
						else
							nxt.minutes = (cur.minutes == 6'd0) ? MINSEC_LAST
								: cur.minutes - 6'd1;
					end
					FIELD_SECOND: begin
						if (up)
							nxt.seconds = (se_inc >= MINSEC_MOD) ? 6'(se_inc - MINSEC_MOD)
								: se_inc[5:0];
						else
							nxt.seconds = (cur.seconds == 6'd0) ? MINSEC_LAST
								: cur.seconds - 6'd1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/core/cfe_weekday.sv -----
// Two-stage weekday path (Zeller) and the result register.
// Depends on cfe_pkg; stage enables come from the top level.
module cfe_weekday (
	input  logic                 clk,
	input  cfe_pkg::wd_ctrl_t    ctrl,
	input  cfe_pkg::edit_state_t st,
	output cfe_pkg::cfe_out_t    rsp
);
	import cfe_pkg::*;

	logic [4:0]  madj;
	logic [13:0] yadj;
	logic [26:0] prod;

	edit_state_t st_s2;
	logic [4:0]  madj_s2;
	logic [13:0] yadj_s2;
	logic [7:0]  cent_s2;

	logic [13:0] hund;
	logic [6:0]  k;
	logic [10:0] sum;
	logic [4:0]  f1;
	logic [3:0]  f2;
	logic [2:0]  h;
	cfe_out_t    rsp_q;

	// Jan/Feb count as months 13/14 of the year before; year zero stays zero
	always_comb begin
		if (st.month < 4'd3) begin
			madj = {1'b0, st.month} + 5'd12;
			yadj = (st.year != 14'd0) ? st.year - 14'd1 : st.year;
		end else begin
			madj = {1'b0, st.month};
			yadj = st.year;
		end
	end

	assign prod = 27'(yadj) * 27'(DIV100_MUL);

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			st_s2   <= st;
			madj_s2 <= madj;
			yadj_s2 <= yadj;
			cent_s2 <= prod[CENT_LSB +: 8];
		end
	end

	assign hund = 14'(cent_s2) * 14'd100;
	assign k    = 7'(yadj_s2 - hund);
	assign sum  = 11'(st_s2.day) + 11'(wd_month_term(madj_s2)) + 11'(k) + 11'(k[6:2])
		+ 11'(cent_s2[7:2]) + 11'(cent_s2) * 11'd5;

	// mod 7 by folding octal digits (8 == 1 mod 7)
	assign f1 = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[8:6]) + 5'(sum[10:9]);
	assign f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
	assign h  = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			rsp_q.field_out   <= st_s2.field;
			rsp_q.month_out   <= st_s2.month;
			rsp_q.day_out     <= st_s2.day;
			rsp_q.year_out    <= st_s2.year;
			rsp_q.hours_out   <= st_s2.hours;
			rsp_q.minutes_out <= st_s2.minutes;
			rsp_q.seconds_out <= st_s2.seconds;
			rsp_q.weekday_out <= wd_code(h);
			rsp_q.edited_out  <= st_s2.edited;
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- rtl/core/calendar_field_editor_unit.sv -----
// Top level of the calendar field editor: APB registers, edit state, result pipeline.
// Depends on cfe_pkg, cfe_edit_step and cfe_weekday.

// The block takes one command per clock while the result side is ready and returns
// one result beat per command, in order. Each beat passes through the edit state,
// the stage-2 register and the result register, where it turns valid. The edit
// registers take their next value in the cycle a command is accepted, so
// back-to-back commands each see the state the previous one left; the weekday is
// then worked out over two registered stages (a constant multiply for the century,
// then the Zeller sum and a mod-7 fold). Each stage holds its beat while the result
// register waits, and a new command is accepted whenever the first stage is free
// or moving on. The low and high year bounds sit at byte addresses 0 and 4 and
// must only be written while no command is in flight.
module calendar_field_editor_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cfe_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  cfe_pkg::cfe_in_t             cmd,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output cfe_pkg::cfe_out_t            rsp
);
	import cfe_pkg::*;

	logic [13:0] year_lo_q;
	logic [13:0] year_hi_q;
	logic        cfg_we;

	edit_state_t state_q;
	edit_state_t state_d;
	logic        v1_q;
	logic        v2_q;
	logic        rsp_valid_q;
	logic        rdy1;
	logic        rdy2;
	logic        rdy3;
	logic        accept;
	wd_ctrl_t    wd_ctrl;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_lo_q <= YEAR_LO_RST;
			year_hi_q <= YEAR_HI_RST;
		end else if (cfg_we) begin
			unique case (paddr[REG_SEL_BIT])
				REG_YEAR_LO: year_lo_q <= pwdata[13:0];
				REG_YEAR_HI: year_hi_q <= pwdata[13:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_YEAR_LO: prdata = {18'd0, year_lo_q};
			REG_YEAR_HI: prdata = {18'd0, year_hi_q};
			default:     prdata = 32'd0;
		endcase
	end

	// Pipeline control: stage 1 is the edit state itself
	assign rdy3      = !rsp_valid_q || rsp_ready;
	assign rdy2      = !v2_q || rdy3;
	assign rdy1      = !v1_q || rdy2;
	assign cmd_ready = rdy1;
	assign accept    = cmd_valid & rdy1;
	assign rsp_valid = rsp_valid_q;

	assign wd_ctrl.load_s2 = v1_q & rdy2;
	assign wd_ctrl.load_s3 = v2_q & rdy3;

	cfe_edit_step u_step (
		.cur     (state_q),
		.cmd     (cmd),
		.year_lo (year_lo_q),
		.year_hi (year_hi_q),
		.nxt     (state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept)
				state_q <= state_d;
			if (rdy1)
				v1_q <= accept;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				rsp_valid_q <= v2_q;
		end
	end

	cfe_weekday u_wd (
		.clk  (clk),
		.ctrl (wd_ctrl),
		.st   (state_q),
		.rsp  (rsp)
	);

`ifndef ASSERT_OFF
	// selector never leaves month..second
	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.field <= FIELD_SECOND)
		else $error("field selector out of range");

	// edited flag is sticky
	a_edited_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.edited |=> state_q.edited)
		else $error("edited flag cleared");

	// an accepted increment or decrement marks the state edited
	a_bump_edits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.command == CMD_INC || cmd.command == CMD_DEC) |=> state_q.edited)
		else $error("edit not flagged");

	// edit state must not move while its beat is held in stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && !rdy2 |=> $stable(state_q))
		else $error("edit state changed under a held beat");

	// weekday code is never zero on a valid result
	a_weekday_nz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.weekday_out != 3'd0)
		else $error("weekday code zero");
`endif

endmodule
